// File: design/lbf_pkg.sv
// Shared types, codes and helper functions for the learning bridge forward core.
package lbf_pkg;

    // Fixed geometry of the block
    localparam int LBF_NUM_PORTS   = 4;
    localparam int LBF_MASK_PORTS  = (LBF_NUM_PORTS > 4) ? 4 : LBF_NUM_PORTS;
    localparam logic [3:0] LBF_PORT_LIMIT = 4'((1 << LBF_MASK_PORTS) - 1);
    localparam int LBF_HASH_W      = 8;
    localparam int LBF_TABLE_DEPTH = 1 << LBF_HASH_W;
    localparam int LBF_MAC_W       = 48;
    localparam int LBF_ENTRY_W     = LBF_MAC_W + 2;

    // Configuration port geometry and register indexes
    localparam int LBF_ADDR_W = 6;
    localparam int LBF_DATA_W = 64;
    localparam logic [2:0] LBF_REG_BRIDGE_ENABLE = 3'd0;
    localparam logic [2:0] LBF_REG_PRESENT_PORTS = 3'd1;
    localparam logic [2:0] LBF_REG_OWN_MAC0      = 3'd2;
    localparam logic [2:0] LBF_REG_OWN_MAC1      = 3'd3;
    localparam logic [2:0] LBF_REG_OWN_MAC2      = 3'd4;
    localparam logic [2:0] LBF_REG_OWN_MAC3      = 3'd5;

    // Addresses and ethertypes
    localparam logic [LBF_MAC_W-1:0] LBF_BCAST_MAC = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] LBF_ETH_IPV4 = 16'h0800;
    localparam logic [15:0] LBF_ETH_IPV6 = 16'h86DD;
    localparam logic [15:0] LBF_ETH_ARP  = 16'h0806;

    // Protocol class codes
    localparam logic [1:0] LBF_CLASS_IPV4  = 2'd0;
    localparam logic [1:0] LBF_CLASS_IPV6  = 2'd1;
    localparam logic [1:0] LBF_CLASS_ARP   = 2'd2;
    localparam logic [1:0] LBF_CLASS_OTHER = 2'd3;

    // Classified request passed from the front end to the table engine
    typedef struct packed {
        logic [1:0]            port;
        logic [LBF_MAC_W-1:0]  dest_mac;
        logic [LBF_MAC_W-1:0]  source_mac;
        logic [LBF_HASH_W-1:0] dest_hash;
        logic [LBF_HASH_W-1:0] source_hash;
        logic                  bridge;
        logic                  learn;
        logic                  deliver;
        logic [1:0]            cls;
    } lbf_req_t;

    // XOR-fold the six address bytes into a table index
    function automatic logic [LBF_HASH_W-1:0] lbf_hash(input logic [LBF_MAC_W-1:0] mac);
        logic [LBF_HASH_W-1:0] h;
        h = '0;
        for (int i = 0; i < 6; i++)
        begin
            h = h ^ mac[8*i +: 8];
        end
        return h;
    endfunction

    // Map an ethertype to its protocol class
    function automatic logic [1:0] lbf_class(input logic [15:0] etype);
        logic [1:0] c;
        if (etype == LBF_ETH_IPV4)
        begin
            c = LBF_CLASS_IPV4;
        end
        else if (etype == LBF_ETH_IPV6)
        begin
            c = LBF_CLASS_IPV6;
        end
        else if (etype == LBF_ETH_ARP)
        begin
            c = LBF_CLASS_ARP;
        end
        else
        begin
            c = LBF_CLASS_OTHER;
        end
        return c;
    endfunction

endpackage

// File: design/lbf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbf_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write on enable, register every read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lbf_front.sv
// Front end: accepts a frame header request and classifies it for the table engine.
module lbf_front
    import lbf_pkg::*;
(
    input  logic                          start,
    input  logic                          queue_full,
    input  logic [1:0]                    ingress_port,
    input  logic [LBF_MAC_W-1:0]          dest_mac,
    input  logic [LBF_MAC_W-1:0]          source_mac,
    input  logic [15:0]                   frame_type,
    input  logic                          bridge_enable,
    input  logic [3:0][LBF_MAC_W-1:0]     own_mac,
    output logic                          push,
    output lbf_req_t                      push_req
);

    logic is_bcast;
    logic is_own;

    // Decide between bridging and local delivery
    assign is_bcast = (dest_mac == LBF_BCAST_MAC);
    assign is_own   = (dest_mac == own_mac[ingress_port]);

    always_comb
    begin
        push_req.port        = ingress_port;
        push_req.dest_mac    = dest_mac;
        push_req.source_mac  = source_mac;
        push_req.dest_hash   = lbf_hash(dest_mac);
        push_req.source_hash = lbf_hash(source_mac);
        push_req.bridge      = bridge_enable && (is_bcast || !is_own);
        push_req.learn       = (source_mac != LBF_BCAST_MAC);
        push_req.deliver     = is_bcast || is_own;
        push_req.cls         = (is_bcast || is_own) ? lbf_class(frame_type) : LBF_CLASS_OTHER;
    end

    // Accept a request whenever the queue has room
    assign push = start && !queue_full;

endmodule

// File: design/lbf_fifo.sv
// Short request queue between the front end and the table engine.
module lbf_fifo
    import lbf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  lbf_req_t push_req,
    input  logic     pop,
    output lbf_req_t head_req,
    output logic     empty,
    output logic     full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lbf_req_t         slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_req = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming request
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// File: design/lbf_back.sv
// Table engine: looks up the destination, learns the source and issues the result.
module lbf_back
    import lbf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       queue_empty,
    input  lbf_req_t   head_req,
    output logic       pop,
    input  logic [3:0] present_ports,
    output logic       result_valid,
    output logic [3:0] forward_mask,
    output logic       deliver_local,
    output logic [1:0] protocol_class,
    output logic       table_hit
);

    typedef enum logic
    {
        ST_LOOKUP,
        ST_RESOLVE
    } state_t;

    state_t                     state_reg, state_next;
    lbf_req_t                   cur_reg;
    logic [LBF_TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                       slot_valid_reg, slot_valid_next;
    logic                       result_valid_reg, result_valid_next;
    logic [3:0]                 forward_mask_reg, forward_mask_next;
    logic                       deliver_local_reg, deliver_local_next;
    logic [1:0]                 protocol_class_reg, protocol_class_next;
    logic                       table_hit_reg, table_hit_next;

    logic [LBF_ENTRY_W-1:0]     ram_rdata;
    logic                       ram_we;
    logic                       match;
    logic [3:0]                 stored_bit;
    logic [3:0]                 ingress_bit;

    // MAC and port of each table entry
    lbf_ram #(
        .WIDTH (LBF_ENTRY_W),
        .DEPTH (LBF_TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cur_reg.source_hash),
        .wdata ({cur_reg.port, cur_reg.source_mac}),
        .raddr (head_req.dest_hash),
        .rdata (ram_rdata)
    );

    assign pop    = (state_reg == ST_LOOKUP) && !queue_empty;
    assign ram_we = (state_reg == ST_RESOLVE) && cur_reg.bridge && cur_reg.learn;

    // Compare the fetched entry against the destination
    assign match       = slot_valid_reg && (ram_rdata[LBF_MAC_W-1:0] == cur_reg.dest_mac);
    assign stored_bit  = 4'b0001 << ram_rdata[LBF_ENTRY_W-1:LBF_MAC_W];
    assign ingress_bit = 4'b0001 << cur_reg.port;

    always_comb
    begin
        state_next          = state_reg;
        valid_next          = valid_reg;
        slot_valid_next     = slot_valid_reg;
        result_valid_next   = 1'b0;
        forward_mask_next   = forward_mask_reg;
        deliver_local_next  = deliver_local_reg;
        protocol_class_next = protocol_class_reg;
        table_hit_next      = table_hit_reg;
        case (state_reg)
            ST_LOOKUP:
            begin
                if (!queue_empty)
                begin
                    slot_valid_next = valid_reg[head_req.dest_hash];
                    state_next      = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                result_valid_next   = 1'b1;
                deliver_local_next  = cur_reg.deliver;
                protocol_class_next = cur_reg.cls;
                table_hit_next      = cur_reg.bridge && match;
                if (!cur_reg.bridge)
                begin
                    forward_mask_next = 4'b0000;
                end
                else if (match)
                begin
                    forward_mask_next = stored_bit;
                end
                else
                begin
                    forward_mask_next = present_ports & LBF_PORT_LIMIT & ~ingress_bit;
                end
                if (ram_we)
                begin
                    valid_next[cur_reg.source_hash] = 1'b1;
                end
                state_next = ST_LOOKUP;
            end
            default:
            begin
                state_next = ST_LOOKUP;
            end
        endcase
    end

    // Hold state, valid bits and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_LOOKUP;
            valid_reg          <= '0;
            slot_valid_reg     <= 1'b0;
            result_valid_reg   <= 1'b0;
            forward_mask_reg   <= '0;
            deliver_local_reg  <= 1'b0;
            protocol_class_reg <= LBF_CLASS_OTHER;
            table_hit_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            valid_reg          <= valid_next;
            slot_valid_reg     <= slot_valid_next;
            result_valid_reg   <= result_valid_next;
            forward_mask_reg   <= forward_mask_next;
            deliver_local_reg  <= deliver_local_next;
            protocol_class_reg <= protocol_class_next;
            table_hit_reg      <= table_hit_next;
        end
    end

    // Latch the request taken from the queue
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head_req;
        end
    end

    assign result_valid   = result_valid_reg;
    assign forward_mask   = forward_mask_reg;
    assign deliver_local  = deliver_local_reg;
    assign protocol_class = protocol_class_reg;
    assign table_hit      = table_hit_reg;

    // A hit names exactly one egress port
    a_hit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && table_hit_reg |-> $onehot(forward_mask_reg))
        else $error("table hit without a single egress port");

    // A frame not delivered locally carries the other class
    a_class_undelivered: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !deliver_local_reg |-> protocol_class_reg == LBF_CLASS_OTHER)
        else $error("undelivered frame with a protocol class");

    // A result follows a resolve step and never comes twice in a row
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |=> !result_valid_reg)
        else $error("results issued back to back");

    // Learning only happens while resolving a bridged request
    a_learn_bridged: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == ST_RESOLVE && cur_reg.bridge)
        else $error("table write outside a bridged resolve");

endmodule

// File: design/learning_bridge_forward_core.sv
// Top level of the learning bridge forward core: configuration registers and wiring.
//
// Usage: drive one frame header request (ingress_port, dest_mac, source_mac,
// frame_type) with start high; it is taken at a rising edge where busy is low.
// Each request yields exactly one result, shown for one cycle with result_valid
// high on forward_mask, deliver_local, protocol_class and table_hit. The
// receiver cannot stall; results must be taken in the cycle they appear.
// The queue registers an accepted request; the table engine pops it in its lookup
// state and registers the result in its resolve state, reading the destination
// entry in the lookup state and writing the learned source entry in the resolve
// state on the 256-entry MAC table RAM; it pops the next request only after that.
// A queue of QUEUE_DEPTH requests sits in front of the engine; busy is high
// while it is full.
// Configuration: APB-style port, 64-bit data, register i at byte address 8*i;
// write only while no request is outstanding.
// Reset: registers return to their reset values and all table valid bits are
// cleared at once, so requests are accepted as soon as reset is released.
module learning_bridge_forward_core
    import lbf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [LBF_ADDR_W-1:0] paddr,
    input  logic [LBF_DATA_W-1:0] pwdata,
    output logic [LBF_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            ingress_port,
    input  logic [47:0]           dest_mac,
    input  logic [47:0]           source_mac,
    input  logic [15:0]           frame_type,
    output logic                  result_valid,
    output logic [3:0]            forward_mask,
    output logic                  deliver_local,
    output logic [1:0]            protocol_class,
    output logic                  table_hit
);

    logic                      bridge_enable_reg;
    logic [3:0]                present_ports_reg;
    logic [3:0][LBF_MAC_W-1:0] own_mac_reg;
    logic [2:0]                reg_index;
    logic                      cfg_write;

    logic     queue_full;
    logic     queue_empty;
    logic     push;
    logic     pop;
    lbf_req_t push_req;
    lbf_req_t head_req;

    assign pready    = 1'b1;
    assign reg_index = paddr[LBF_ADDR_W-1:3];
    assign cfg_write = psel && penable && pwrite;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bridge_enable_reg <= 1'b0;
            present_ports_reg <= 4'hF;
            own_mac_reg       <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                LBF_REG_BRIDGE_ENABLE: bridge_enable_reg <= pwdata[0];
                LBF_REG_PRESENT_PORTS: present_ports_reg <= pwdata[3:0];
                LBF_REG_OWN_MAC0:      own_mac_reg[0]    <= pwdata[LBF_MAC_W-1:0];
                LBF_REG_OWN_MAC1:      own_mac_reg[1]    <= pwdata[LBF_MAC_W-1:0];
                LBF_REG_OWN_MAC2:      own_mac_reg[2]    <= pwdata[LBF_MAC_W-1:0];
                LBF_REG_OWN_MAC3:      own_mac_reg[3]    <= pwdata[LBF_MAC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Return register contents on reads
    always_comb
    begin
        case (reg_index)
            LBF_REG_BRIDGE_ENABLE: prdata = {63'd0, bridge_enable_reg};
            LBF_REG_PRESENT_PORTS: prdata = {60'd0, present_ports_reg};
            LBF_REG_OWN_MAC0:      prdata = {16'd0, own_mac_reg[0]};
            LBF_REG_OWN_MAC1:      prdata = {16'd0, own_mac_reg[1]};
            LBF_REG_OWN_MAC2:      prdata = {16'd0, own_mac_reg[2]};
            LBF_REG_OWN_MAC3:      prdata = {16'd0, own_mac_reg[3]};
            default:               prdata = '0;
        endcase
    end

    assign busy = queue_full;

    lbf_front u_front (
        .start         (start),
        .queue_full    (queue_full),
        .ingress_port  (ingress_port),
        .dest_mac      (dest_mac),
        .source_mac    (source_mac),
        .frame_type    (frame_type),
        .bridge_enable (bridge_enable_reg),
        .own_mac       (own_mac_reg),
        .push          (push),
        .push_req      (push_req)
    );

    lbf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .head_req (head_req),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    lbf_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .queue_empty    (queue_empty),
        .head_req       (head_req),
        .pop            (pop),
        .present_ports  (present_ports_reg),
        .result_valid   (result_valid),
        .forward_mask   (forward_mask),
        .deliver_local  (deliver_local),
        .protocol_class (protocol_class),
        .table_hit      (table_hit)
    );

endmodule

// File: verif/learning_bridge_forward_core_tb.sv
// Self-checking testbench for the learning bridge forward core: directed table, then random traffic.
`timescale 1ns / 100ps

module learning_bridge_forward_core_tb;
    import lbf_pkg::*;

    localparam int STALL_LIMIT      = 2000;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 235;
    localparam int MAC_POOL_SIZE    = 32;
    localparam int DRAIN_CYCLES     = 20;

    typedef struct packed {
        logic [1:0]  port;
        logic [47:0] dst;
        logic [47:0] src;
        logic [15:0] etype;
    } header_t;

    typedef struct packed {
        logic [3:0] fwd;
        logic       deliver;
        logic [1:0] cls;
        logic       hit;
    } verdict_t;

    typedef enum int {DIR_RESET_CFG, DIR_BRIDGE_ON, DIR_NO_FLOOD} dir_phase_e;

    typedef struct {
        dir_phase_e phase;
        header_t    hdr;
        logic       typed;
        verdict_t   want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [LBF_ADDR_W-1:0] paddr;
    logic [LBF_DATA_W-1:0] pwdata;
    logic [LBF_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  start;
    logic                  busy;
    logic [1:0]            ingress_port;
    logic [47:0]           dest_mac;
    logic [47:0]           source_mac;
    logic [15:0]           frame_type;
    logic                  result_valid;
    logic [3:0]            forward_mask;
    logic                  deliver_local;
    logic [1:0]            protocol_class;
    logic                  table_hit;

    // Shadow of the MAC table and the configuration
    logic [47:0] mac_table_addr  [LBF_TABLE_DEPTH];
    logic [1:0]  mac_table_port  [LBF_TABLE_DEPTH];
    logic        mac_table_valid [LBF_TABLE_DEPTH];
    logic        bridge_on;
    logic [3:0]  port_present;
    logic [47:0] port_own_mac [4];

    verdict_t    expected_verdicts [$];
    dir_row_t    directed_rows [$];
    logic [47:0] mac_pool [MAC_POOL_SIZE];
    int          fail_count  = 0;
    int          idle_cycles = 0;

    learning_bridge_forward_core u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .ingress_port   (ingress_port),
        .dest_mac       (dest_mac),
        .source_mac     (source_mac),
        .frame_type     (frame_type),
        .result_valid   (result_valid),
        .forward_mask   (forward_mask),
        .deliver_local  (deliver_local),
        .protocol_class (protocol_class),
        .table_hit      (table_hit)
    );

    always #6 clk = ~clk;

    // XOR-fold the six address bytes into a table index
    function automatic logic [7:0] fold_mac(input logic [47:0] mac);
        return mac[47:40] ^ mac[39:32] ^ mac[31:24] ^ mac[23:16] ^ mac[15:8] ^ mac[7:0];
    endfunction

    // Decide forwarding and delivery for one header, learning the source as the block does
    function automatic verdict_t forward_decision(input header_t h);
        verdict_t   v;
        logic       bridged;
        logic [7:0] d_idx;
        logic [7:0] s_idx;
        v.fwd     = 4'd0;
        v.deliver = 1'b0;
        v.cls     = LBF_CLASS_OTHER;
        v.hit     = 1'b0;
        bridged   = 1'b0;
        if (h.dst == LBF_BCAST_MAC)
        begin
            bridged   = bridge_on;
            v.deliver = 1'b1;
        end
        else if (h.dst != port_own_mac[h.port])
        begin
            bridged = bridge_on;
        end
        else
        begin
            v.deliver = 1'b1;
        end
        if (bridged)
        begin
            d_idx = fold_mac(h.dst);
            if (mac_table_valid[d_idx] && mac_table_addr[d_idx] == h.dst)
            begin
                v.hit = 1'b1;
                v.fwd = 4'b0001 << mac_table_port[d_idx];
            end
            else
            begin
                v.fwd = port_present & LBF_PORT_LIMIT & ~(4'b0001 << h.port);
            end
            // learn the source unless it is broadcast; overwrite any old entry
            if (h.src != LBF_BCAST_MAC)
            begin
                s_idx = fold_mac(h.src);
                mac_table_addr[s_idx]  = h.src;
                mac_table_port[s_idx]  = h.port;
                mac_table_valid[s_idx] = 1'b1;
            end
        end
        if (v.deliver)
        begin
            case (h.etype)
                LBF_ETH_IPV4: v.cls = LBF_CLASS_IPV4;
                LBF_ETH_IPV6: v.cls = LBF_CLASS_IPV6;
                LBF_ETH_ARP:  v.cls = LBF_CLASS_ARP;
                default:      v.cls = LBF_CLASS_OTHER;
            endcase
        end
        return v;
    endfunction

    // Pick an own-MAC register value, extremes included, with junk in the unused upper bits
    function automatic logic [63:0] pick_own_mac_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       w[47:0] = 48'h0;
            1:       w[47:0] = LBF_BCAST_MAC;
            2:       w[47:0] = 48'hFFFF_FFFF_FFFE;
            3, 4:    w[47:0] = mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
            default: ;
        endcase
        return w;
    endfunction

    task automatic add_row(input dir_phase_e phase, input logic [1:0] port,
                           input logic [47:0] dst, input logic [47:0] src,
                           input logic [15:0] etype, input logic typed,
                           input logic [3:0] fwd, input logic deliver,
                           input logic [1:0] cls, input logic hit);
        dir_row_t r;
        r.phase        = phase;
        r.hdr.port     = port;
        r.hdr.dst      = dst;
        r.hdr.src      = src;
        r.hdr.etype    = etype;
        r.typed        = typed;
        r.want.fwd     = fwd;
        r.want.deliver = deliver;
        r.want.cls     = cls;
        r.want.hit     = hit;
        directed_rows.push_back(r);
    endtask

    // Write one register over the APB port and mirror it in the shadow configuration
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            LBF_REG_BRIDGE_ENABLE: bridge_on       = value[0];
            LBF_REG_PRESENT_PORTS: port_present    = value[3:0];
            LBF_REG_OWN_MAC0:      port_own_mac[0] = value[47:0];
            LBF_REG_OWN_MAC1:      port_own_mac[1] = value[47:0];
            LBF_REG_OWN_MAC2:      port_own_mac[2] = value[47:0];
            LBF_REG_OWN_MAC3:      port_own_mac[3] = value[47:0];
            default:               ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_config(input logic [63:0] en, input logic [63:0] present,
                               input logic [63:0] mac0, input logic [63:0] mac1,
                               input logic [63:0] mac2, input logic [63:0] mac3);
        write_reg(LBF_REG_BRIDGE_ENABLE, en);
        write_reg(LBF_REG_PRESENT_PORTS, present);
        write_reg(LBF_REG_OWN_MAC0, mac0);
        write_reg(LBF_REG_OWN_MAC1, mac1);
        write_reg(LBF_REG_OWN_MAC2, mac2);
        write_reg(LBF_REG_OWN_MAC3, mac3);
    endtask

    // Issue one request after a gap; called and returns at a falling edge
    task automatic send_header(input header_t h, input int gap, input logic typed,
                               input verdict_t want);
        verdict_t v;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start        <= 1'b1;
        ingress_port <= h.port;
        dest_mac     <= h.dst;
        source_mac   <= h.src;
        frame_type   <= h.etype;
        do @(posedge clk); while (busy);
        v = forward_decision(h);
        expected_verdicts.push_back(typed ? want : v);
        @(negedge clk);
    endtask

    // Drop start and hold until every pending request has produced its result
    task automatic wait_idle();
        start <= 1'b0;
        while (expected_verdicts.size() != 0) @(negedge clk);
    endtask

    // Compare each result against the oldest pending expectation
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && result_valid)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $error("result with no request pending: mask %h", forward_mask);
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (forward_mask !== want.fwd)
                begin
                    $error("forward_mask: expected %h, got %h", want.fwd, forward_mask);
                    fail_count++;
                end
                if (deliver_local !== want.deliver)
                begin
                    $error("deliver_local: expected %b, got %b", want.deliver, deliver_local);
                    fail_count++;
                end
                if (protocol_class !== want.cls)
                begin
                    $error("protocol_class: expected %0d, got %0d", want.cls, protocol_class);
                    fail_count++;
                end
                if (table_hit !== want.hit)
                begin
                    $error("table_hit: expected %b, got %b", want.hit, table_hit);
                    fail_count++;
                end
            end
        end
    end

    // Abort when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (psel && penable))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAIL learning_bridge_forward_core");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        header_t     h;
        logic [63:0] r64;
        logic [63:0] en_word;
        logic [63:0] present_word;
        logic [7:0]  b;
        int          sel;
        int          gap;
        logic        steady;

        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        start        = 1'b0;
        ingress_port = '0;
        dest_mac     = '0;
        source_mac   = '0;
        frame_type   = '0;

        bridge_on    = 1'b0;
        port_present = 4'hF;
        for (int p = 0; p < 4; p++)
        begin
            port_own_mac[p] = '0;
        end
        for (int i = 0; i < LBF_TABLE_DEPTH; i++)
        begin
            mac_table_addr[i]  = '0;
            mac_table_port[i]  = '0;
            mac_table_valid[i] = 1'b0;
        end

        // Half the pool is random, the other half collides on the hash with it
        for (int i = 0; i < MAC_POOL_SIZE / 2; i++)
        begin
            r64 = {$urandom, $urandom};
            mac_pool[i] = r64[47:0];
        end
        for (int i = MAC_POOL_SIZE / 2; i < MAC_POOL_SIZE; i++)
        begin
            b = 8'($urandom_range(1, 255));
            mac_pool[i] = mac_pool[i - MAC_POOL_SIZE / 2] ^ {b, b, 32'h0};
        end

        // Reset configuration: bridging off, every own MAC zero
        add_row(DIR_RESET_CFG, 2'd0, 48'h0, 48'h1, LBF_ETH_IPV4,
                1'b1, 4'h0, 1'b1, LBF_CLASS_IPV4, 1'b0);
        add_row(DIR_RESET_CFG, 2'd1, LBF_BCAST_MAC, LBF_BCAST_MAC, LBF_ETH_IPV6,
                1'b1, 4'h0, 1'b1, LBF_CLASS_IPV6, 1'b0);
        add_row(DIR_RESET_CFG, 2'd2, 48'h1234_5678_9ABC, 48'h2, LBF_ETH_ARP,
                1'b1, 4'h0, 1'b0, LBF_CLASS_OTHER, 1'b0);
        add_row(DIR_RESET_CFG, 2'd3, 48'h0, 48'h3, 16'h1234,
                1'b1, 4'h0, 1'b1, LBF_CLASS_OTHER, 1'b0);
        // Bridging on: miss and flood, hits, hit on the ingress port, collisions
        add_row(DIR_BRIDGE_ON, 2'd0, 48'hAAAA_0000_0001, 48'h10, LBF_ETH_IPV4,
                1'b1, 4'hE, 1'b0, LBF_CLASS_OTHER, 1'b0);
        add_row(DIR_BRIDGE_ON, 2'd1, 48'h10, 48'h20, LBF_ETH_IPV4,
                1'b1, 4'h1, 1'b0, LBF_CLASS_OTHER, 1'b1);
        add_row(DIR_BRIDGE_ON, 2'd2, 48'h10, LBF_BCAST_MAC, LBF_ETH_ARP,
                1'b1, 4'h1, 1'b0, LBF_CLASS_OTHER, 1'b1);
        add_row(DIR_BRIDGE_ON, 2'd0, 48'h20, 48'h10, LBF_ETH_IPV6,
                1'b1, 4'h2, 1'b0, LBF_CLASS_OTHER, 1'b1);
        add_row(DIR_BRIDGE_ON, 2'd0, 48'h10, 48'h40, LBF_ETH_IPV4,
                1'b1, 4'h1, 1'b0, LBF_CLASS_OTHER, 1'b1);
        add_row(DIR_BRIDGE_ON, 2'd3, LBF_BCAST_MAC, 48'h30, LBF_ETH_ARP,
                1'b1, 4'h7, 1'b1, LBF_CLASS_ARP, 1'b0);
        add_row(DIR_BRIDGE_ON, 2'd1, 48'h0200_0000_0002, 48'h31, LBF_ETH_IPV6,
                1'b1, 4'h0, 1'b1, LBF_CLASS_IPV6, 1'b0);
        add_row(DIR_BRIDGE_ON, 2'd2, 48'h0200_0000_0002, 48'h0200_0000_0003, LBF_ETH_IPV4,
                1'b0, 4'h0, 1'b0, LBF_CLASS_OTHER, 1'b0);
        add_row(DIR_BRIDGE_ON, 2'd3, 48'h20, 48'h1000, LBF_ETH_IPV4,
                1'b1, 4'h2, 1'b0, LBF_CLASS_OTHER, 1'b1);
        add_row(DIR_BRIDGE_ON, 2'd2, 48'h10, 48'h50, LBF_ETH_IPV4,
                1'b1, 4'hB, 1'b0, LBF_CLASS_OTHER, 1'b0);
        add_row(DIR_BRIDGE_ON, 2'd0, 48'h1000, 48'h0, 16'h0000,
                1'b1, 4'h8, 1'b0, LBF_CLASS_OTHER, 1'b1);
        add_row(DIR_BRIDGE_ON, 2'd1, 48'h0, 48'hFFFF_FFFF_FFFE, 16'hFFFF,
                1'b0, 4'h0, 1'b0, LBF_CLASS_OTHER, 1'b0);
        add_row(DIR_BRIDGE_ON, 2'd2, 48'hFFFF_FFFF_FFFE, LBF_BCAST_MAC, 16'h0000,
                1'b0, 4'h0, 1'b0, LBF_CLASS_OTHER, 1'b0);
        // No ports present; own MACs at the extremes
        add_row(DIR_NO_FLOOD, 2'd0, 48'hAAAA_0000_0001, 48'h60, LBF_ETH_IPV4,
                1'b1, 4'h0, 1'b0, LBF_CLASS_OTHER, 1'b0);
        add_row(DIR_NO_FLOOD, 2'd2, LBF_BCAST_MAC, 48'h70, LBF_ETH_IPV4,
                1'b1, 4'h0, 1'b1, LBF_CLASS_IPV4, 1'b0);
        add_row(DIR_NO_FLOOD, 2'd3, 48'hFFFF_FFFF_FFFE, 48'h80, LBF_ETH_IPV6,
                1'b1, 4'h0, 1'b1, LBF_CLASS_IPV6, 1'b0);

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed table
        foreach (directed_rows[i])
        begin
            if (i > 0)
            begin
                if (directed_rows[i].phase != directed_rows[i - 1].phase)
                begin
                    wait_idle();
                    case (directed_rows[i].phase)
                        DIR_BRIDGE_ON:
                            load_config(64'h1, 64'hF, 64'h0200_0000_0001, 64'h0200_0000_0002,
                                        64'h0200_0000_0003, 64'h0200_0000_0004);
                        DIR_NO_FLOOD:
                            load_config(64'h1, 64'h0, 64'h0200_0000_0001, 64'h0200_0000_0002,
                                        {16'h0, LBF_BCAST_MAC}, 64'h0000_FFFF_FFFF_FFFE);
                        default: ;
                    endcase
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            send_header(directed_rows[i].hdr, gap, directed_rows[i].typed,
                        directed_rows[i].want);
        end

        // Random traffic, one configuration per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            wait_idle();
            en_word    = {$urandom, $urandom};
            en_word[0] = (ph % 4 != 3);
            present_word = {$urandom, $urandom};
            if (ph == 0)
            begin
                present_word[3:0] = 4'hF;
            end
            else if (ph == 1)
            begin
                present_word[3:0] = 4'h0;
            end
            load_config(en_word, present_word, pick_own_mac_word(), pick_own_mac_word(),
                        pick_own_mac_word(), pick_own_mac_word());
            steady = ($urandom_range(0, 2) == 0);
            for (int n = 0; n < FRAMES_PER_PHASE; n++)
            begin
                h.port = 2'($urandom_range(0, 3));
                sel = $urandom_range(0, 99);
                r64 = {$urandom, $urandom};
                if (sel < 10)
                    h.dst = LBF_BCAST_MAC;
                else if (sel < 25)
                    h.dst = port_own_mac[h.port];
                else if (sel < 30)
                    h.dst = port_own_mac[$urandom_range(0, 3)];
                else if (sel < 37)
                    h.dst = r64[47:0];
                else
                    h.dst = mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
                sel = $urandom_range(0, 99);
                r64 = {$urandom, $urandom};
                if (sel < 5)
                    h.src = LBF_BCAST_MAC;
                else if (sel < 20)
                    h.src = r64[47:0];
                else
                    h.src = mac_pool[$urandom_range(0, MAC_POOL_SIZE - 1)];
                case ($urandom_range(0, 9))
                    0, 1:    h.etype = LBF_ETH_IPV4;
                    2, 3:    h.etype = LBF_ETH_IPV6;
                    4, 5:    h.etype = LBF_ETH_ARP;
                    6:       h.etype = LBF_ETH_IPV4 ^ (16'h1 << $urandom_range(0, 15));
                    default: h.etype = 16'($urandom);
                endcase
                gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
                send_header(h, gap, 1'b0, '0);
            end
        end

        // Drain and let any stray result show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_verdicts.size() != 0)
        begin
            $error("%0d results never arrived", expected_verdicts.size());
            fail_count++;
        end
        if (fail_count == 0)
        begin
            $display("PASS learning_bridge_forward_core");
        end
        else
        begin
            $display("FAIL learning_bridge_forward_core");
        end
        $finish;
    end

endmodule
